[design/base32_codec_custom_alphabet_top_macros.svh]
// Assertion helpers included by the top-level design file.
// Every check is clocked on i_clk and switched off while i_rst_n is low.
`ifndef BASE32_CODEC_CUSTOM_ALPHABET_TOP_MACROS_SVH
`define BASE32_CODEC_CUSTOM_ALPHABET_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define B32C_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define B32C_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[design/b32c_pkg.sv]
`default_nettype none

package b32c_pkg;

    localparam int ALPHA_SIZE = 32;
    localparam int CNT_W      = 4;
    localparam int STORE_W    = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int MAX_RES    = 3;

    typedef logic [CNT_W-1:0]        t_count;
    typedef logic [STORE_W-1:0]      t_store;
    typedef logic [4:0]              t_sym;
    typedef logic [ALPHA_SIZE-1:0][7:0] t_alphabet;

    localparam t_count SYM_BITS  = 4'd5;
    localparam t_count BYTE_BITS = 4'd8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_0   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_1   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_2   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_3   = 3'd4;

    typedef enum logic {
        DIR_ENCODE = 1'b0,
        DIR_DECODE = 1'b1
    } t_dir;

    typedef struct packed {
        logic [7:0] data;
        logic       has_data;
        logic       last;
        logic       bad;
    } t_result;

    // Everything one item produces, plus the accumulator it leaves behind.
    typedef struct packed {
        logic [1:0]               n;
        t_result [MAX_RES-1:0]    res;
        t_store                   store;
        t_count                   count;
    } t_step;

    function automatic logic [7:0] alpha_char(t_alphabet alpha, t_sym idx);
        return alpha[idx];
    endfunction

endpackage

`default_nettype wire

[design/base32_codec_custom_alphabet_top.sv]
`default_nettype none

// Streaming base32 codec with a programmable 32-character alphabet and no
// padding characters. With direction 0 the block takes data bytes and gives
// alphabet characters, five bits each, most significant bit first; the item
// marked last has its leftover bits padded with zeros into one final
// character. With direction 1 it takes characters, looks each one up in the
// alphabet (the lowest matching index wins, an unknown character counts as
// index zero and raises bad_symbol) and gives a byte for every eight bits
// gathered, dropping the leftover bits at the end of the message. A decode
// item that completes no byte but ends the message or holds an unknown
// character still gives one result with has_data low. Writing the direction
// register empties the bit accumulator, so write it between messages only.
// An input item is held in an input register while its results are worked
// out in one pass of logic, and the results leave one at a time through a
// single output register. An item is therefore taken every cycle while each
// item gives at most one result and the output is not stalled; an item that
// gives two or three results holds the input register until its final result
// has moved out, so encoding runs at about eight results per five items,
// limited by the one result per cycle of the output register. An accepted
// item's first result passes through the input register and then the output
// register before it is presented at the output.
module base32_codec_custom_alphabet_top
    import b32c_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,

    input  wire                   i_cfg_we,
    input  wire [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire [CFG_DATA_W-1:0]  i_cfg_data,

    input  wire                   i_in_valid,
    output logic                  o_in_stall,
    input  wire [7:0]             i_in_byte,
    input  wire                   i_in_last,

    output logic                  o_out_valid,
    input  wire                   i_out_stall,
    output logic [7:0]            o_out_byte,
    output logic                  o_has_data,
    output logic                  o_out_last,
    output logic                  o_bad_symbol
);

    `include "base32_codec_custom_alphabet_top_macros.svh"

    // Configuration registers.
    t_dir                   r_direction;
    logic [3:0][63:0]       r_alpha;
    t_alphabet              alphabet;

    // Bit accumulator carried from item to item.
    t_store                 r_store, n_store;
    t_count                 r_count, n_count;

    // Input register: the item whose results are being issued.
    logic                   r_in_valid;
    logic [7:0]             r_in_byte;
    logic                   r_in_last;
    logic [1:0]             r_idx, n_idx;

    // Output register.
    logic                   r_out_valid;
    t_result                r_out;

    t_step                  step;
    t_result                sel_res;
    logic                   in_accept;
    logic                   out_free;
    logic                   out_load;
    logic                   cur_done;
    logic                   dir_write;

    assign alphabet = r_alpha;

    b32c_step u_step (
        .i_direction (r_direction),
        .i_alpha     (alphabet),
        .i_store     (r_store),
        .i_count     (r_count),
        .i_byte      (r_in_byte),
        .i_last      (r_in_last),
        .o_step      (step)
    );

    // Result of the held item that is due next.
    always_comb begin
        case (r_idx)
            2'd0:    sel_res = step.res[0];
            2'd1:    sel_res = step.res[1];
            default: sel_res = step.res[2];
        endcase
    end

    // The output register can take a result when it is empty or being read.
    assign out_free  = !r_out_valid || !i_out_stall;
    assign out_load  = r_in_valid && (step.n != 2'd0) && out_free;
    // The held item is finished when its final result moves out, or at once
    // when it gives no result at all.
    assign cur_done  = r_in_valid &&
                       ((step.n == 2'd0) || (out_load && (r_idx == step.n - 2'd1)));
    assign o_in_stall = r_in_valid && !cur_done;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign dir_write  = i_cfg_we && (i_cfg_index == CFG_DIRECTION);

    always_comb begin
        n_idx = r_idx;
        if (cur_done) begin
            n_idx = 2'd0;
        end else if (out_load) begin
            n_idx = r_idx + 2'd1;
        end
    end

    always_comb begin
        n_store = r_store;
        n_count = r_count;
        if (dir_write) begin
            n_store = '0;
            n_count = '0;
        end else if (cur_done) begin
            n_store = step.store;
            n_count = step.count;
        end
    end

    // Configuration writes; an index beyond the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction <= DIR_ENCODE;
            r_alpha     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DIRECTION: r_direction <= t_dir'(i_cfg_data[0]);
                CFG_ALPHA_0:   r_alpha[0]  <= i_cfg_data;
                CFG_ALPHA_1:   r_alpha[1]  <= i_cfg_data;
                CFG_ALPHA_2:   r_alpha[2]  <= i_cfg_data;
                CFG_ALPHA_3:   r_alpha[3]  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_store     <= '0;
            r_count     <= '0;
            r_in_valid  <= 1'b0;
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_store <= n_store;
            r_count <= n_count;
            r_idx   <= n_idx;
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (cur_done) begin
                r_in_valid <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_in_byte;
            r_in_last <= i_in_last;
        end
        if (out_load) begin
            r_out <= sel_res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_byte   = r_out.data;
    assign o_has_data   = r_out.has_data;
    assign o_out_last   = r_out.last;
    assign o_bad_symbol = r_out.bad;

    // An accepted item is held in the input register in the next cycle.
    `B32C_ASSERT_NEXT(a_in_held, in_accept, r_in_valid, "accepted item was not held")
    // Issuing the final result of a message leaves the accumulator empty.
    `B32C_ASSERT_NEXT(a_last_clears, out_load && sel_res.last, r_count == '0,
        "accumulator not emptied at end of message")
    // Fewer than eight bits ever wait in the accumulator.
    `B32C_ASSERT_NOW(a_count_range, 1'b1, r_count < BYTE_BITS, "bit count out of range")
    // Bits above the count are always clear.
    `B32C_ASSERT_NOW(a_store_clean, 1'b1, (r_store >> r_count) == '0,
        "stale bits above the count")

endmodule

`default_nettype wire

[design/b32c_search.sv]
`default_nettype none

module b32c_search
    import b32c_pkg::*;
(
    input  var t_alphabet  i_alpha,
    input  wire [7:0]      i_char,
    output t_sym           o_idx,
    output logic           o_found
);

    // Scanned from the top down so that the lowest matching index wins.
    always_comb begin
        o_idx   = '0;
        o_found = 1'b0;
        for (int i = ALPHA_SIZE - 1; i >= 0; i--) begin
            if (i_alpha[i] == i_char) begin
                o_idx   = t_sym'(i);
                o_found = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

[design/b32c_step.sv]
`default_nettype none

module b32c_step
    import b32c_pkg::*;
(
    input  var t_dir       i_direction,
    input  var t_alphabet  i_alpha,
    input  var t_store     i_store,
    input  var t_count     i_count,
    input  wire [7:0]      i_byte,
    input  wire            i_last,
    output t_step          o_step
);

    // Encode path.
    t_count      enc_c0, enc_c, enc_c1, enc_c2, enc_cf;
    logic [12:0] enc_acc, enc_sh0, enc_sh1, enc_pad_sh, enc_mask;
    logic        enc_two, enc_pad;
    t_sym        enc_idx0, enc_idx1, enc_pad_idx;

    // Decode path.
    t_sym        dec_idx;
    logic        dec_found, dec_bad, dec_got;
    t_count      dec_c0, dec_c, dec_c1, dec_cf;
    logic [11:0] dec_acc, dec_sh, dec_mask;

    t_step       step;

    b32c_search u_search (
        .i_alpha (i_alpha),
        .i_char  (i_byte),
        .o_idx   (dec_idx),
        .o_found (dec_found)
    );

    always_comb begin
        enc_c0      = (i_count >= SYM_BITS) ? (SYM_BITS - 4'd1) : i_count;
        enc_acc     = {i_store[4:0], i_byte};
        enc_c       = enc_c0 + BYTE_BITS;
        enc_c1      = enc_c - SYM_BITS;
        enc_sh0     = enc_acc >> enc_c1;
        enc_idx0    = enc_sh0[4:0];
        enc_two     = (enc_c1 >= SYM_BITS);
        enc_c2      = enc_c1 - SYM_BITS;
        enc_sh1     = enc_acc >> enc_c2;
        enc_idx1    = enc_sh1[4:0];
        enc_cf      = enc_two ? enc_c2 : enc_c1;
        enc_pad     = i_last && (enc_cf != '0);
        enc_pad_sh  = enc_acc << (SYM_BITS - enc_cf);
        enc_pad_idx = enc_pad_sh[4:0];
        enc_mask    = (13'd1 << enc_cf) - 13'd1;

        dec_bad  = !dec_found;
        dec_c0   = (i_count >= BYTE_BITS) ? (BYTE_BITS - 4'd1) : i_count;
        dec_acc  = {i_store[6:0], dec_idx};
        dec_c    = dec_c0 + SYM_BITS;
        dec_got  = (dec_c >= BYTE_BITS);
        dec_c1   = dec_c - BYTE_BITS;
        dec_sh   = dec_acc >> dec_c1;
        dec_cf   = dec_got ? dec_c1 : dec_c;
        dec_mask = (12'd1 << dec_cf) - 12'd1;

        step = '0;
        if (i_direction == DIR_ENCODE) begin
            step.res[0] = '{data: alpha_char(i_alpha, enc_idx0), has_data: 1'b1,
                            last: 1'b0, bad: 1'b0};
            if (enc_two || enc_pad) begin
                step.res[1] = '{data: alpha_char(i_alpha, enc_two ? enc_idx1 : enc_pad_idx),
                                has_data: 1'b1, last: 1'b0, bad: 1'b0};
            end
            if (enc_two && enc_pad) begin
                step.res[2] = '{data: alpha_char(i_alpha, enc_pad_idx), has_data: 1'b1,
                                last: 1'b0, bad: 1'b0};
            end
            step.n     = 2'd1 + {1'b0, enc_two} + {1'b0, enc_pad};
            step.store = t_store'(enc_acc & enc_mask);
            step.count = enc_cf;
        end else begin
            if (dec_got) begin
                step.res[0] = '{data: dec_sh[7:0], has_data: 1'b1, last: 1'b0,
                                bad: dec_bad};
            end else begin
                // No byte completed: an empty result still carries the end
                // of message or the bad-character flag.
                step.res[0] = '{data: 8'd0, has_data: 1'b0, last: 1'b0, bad: dec_bad};
            end
            step.n     = (dec_got || i_last || dec_bad) ? 2'd1 : 2'd0;
            step.store = dec_acc & dec_mask;
            step.count = dec_cf;
        end

        // The message ends here: flag its final result and empty the store.
        if (i_last) begin
            case (step.n)
                2'd1:    step.res[0].last = 1'b1;
                2'd2:    step.res[1].last = 1'b1;
                2'd3:    step.res[2].last = 1'b1;
                default: ;
            endcase
            step.store = '0;
            step.count = '0;
        end

        o_step = step;
    end

endmodule

`default_nettype wire
